/* sv/md5_stream_hash_defines.svh */
// Assertion macros for the MD5 stream hash block.
`ifndef MD5_STREAM_HASH_DEFINES_SVH
`define MD5_STREAM_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/md5_pkg.sv */
// Types, constants and round functions shared by the MD5 stream hash modules.
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } md5_state_t;

    // Datapath commands from the controller.
    typedef struct packed {
        logic       write_byte;   // write byte_sel at buffer offset
        logic [1:0] byte_src;     // see BSRC_*
        logic       count_inc;    // advance message byte count
        logic       pos_inc;      // advance block offset
        logic       round_start;  // copy chain into round words
        logic       round_step;   // one MD5 round
        logic       chain_add;    // add round words into chain
        logic       emit_load;    // latch chain into output register
        logic       emit_next;    // advance output word
        logic       msg_clear;    // back to initial chain, zero count
    } md5_cmd_t;

    typedef struct packed {
        logic       block_full;   // offset is 63
        logic       pad_done;     // offset is 55 (next is length field)
        logic       len_done;     // offset is 63 in length field
        logic       round_last;   // round index is 63
        logic       out_busy;     // output register holds an item
        logic       out_last;     // output holds D word
        logic       out_take;     // output item accepted this cycle
    } md5_status_t;

    localparam logic [1:0] BSRC_DATA = 2'd0;
    localparam logic [1:0] BSRC_PAD  = 2'd1;
    localparam logic [1:0] BSRC_ZERO = 2'd2;
    localparam logic [1:0] BSRC_LEN  = 2'd3;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] shift_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

/* sv/md5_datapath.sv */
// MD5 datapath: block buffer, byte count, round unit, chaining words, output register.
module md5_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  md5_pkg::md5_cmd_t    cmd,
    output md5_pkg::md5_status_t status,
    input  logic [7:0]           data_byte,
    input  logic                 out_ready,
    output logic [31:0]          digest_word,
    output logic [1:0]           word_index,
    output logic                 last_word
);
    import md5_pkg::*;

    logic [31:0] buf_mem [16];
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] ca_next, cb_next, cc_next, cd_next;
    logic [1:0]  oidx_reg, oidx_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oword_reg, oword_next;
    logic [7:0]  byte_sel;
    logic [63:0] bit_len;
    logic [3:0]  sel;
    logic [31:0] mix, sum, rot, mword;

    assign bit_len = {count_reg, 3'b000};

    always_comb
    begin
        case (cmd.byte_src)
            BSRC_DATA: byte_sel = data_byte;
            BSRC_PAD:  byte_sel = PAD_BYTE;
            BSRC_ZERO: byte_sel = 8'h00;
            default:   byte_sel = bit_len[{pos_reg[2:0], 3'b000} +: 8];
        endcase
    end

    // Byte lanes of a word; the first byte of a word clears the rest.
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            case (pos_reg[1:0])
                2'd0:    buf_mem[pos_reg[5:2]] <= {24'h0, byte_sel};
                2'd1:    buf_mem[pos_reg[5:2]][15:8] <= byte_sel;
                2'd2:    buf_mem[pos_reg[5:2]][23:16] <= byte_sel;
                default: buf_mem[pos_reg[5:2]][31:24] <= byte_sel;
            endcase
        end
    end

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:
            begin
                mix = (b_reg & c_reg) | (~b_reg & d_reg);
                sel = rnd_reg[3:0];
            end
            2'd1:
            begin
                mix = (b_reg & d_reg) | (c_reg & ~d_reg);
                sel = 4'((rnd_reg[3:0] << 2) + rnd_reg[3:0] + 4'd1);
            end
            2'd2:
            begin
                mix = b_reg ^ c_reg ^ d_reg;
                sel = 4'((rnd_reg[3:0] << 1) + rnd_reg[3:0] + 4'd5);
            end
            default:
            begin
                mix = c_reg ^ (b_reg | ~d_reg);
                sel = 4'((rnd_reg[3:0] << 3) - rnd_reg[3:0]);
            end
        endcase
        mword = buf_mem[sel];
        sum = a_reg + mix + round_const(rnd_reg) + mword;
        rot = (sum << shift_amount(rnd_reg)) | (sum >> (6'd32 - {1'b0, shift_amount(rnd_reg)}));
    end

    always_comb
    begin
        pos_next = pos_reg;
        count_next = count_reg;
        rnd_next = rnd_reg;
        {a_next, b_next, c_next, d_next} = {a_reg, b_reg, c_reg, d_reg};
        {ca_next, cb_next, cc_next, cd_next} = {ca_reg, cb_reg, cc_reg, cd_reg};
        oidx_next = oidx_reg;
        ovalid_next = ovalid_reg;
        oword_next = oword_reg;
        if (cmd.pos_inc)
            pos_next = pos_reg + 6'd1;
        if (cmd.count_inc)
            count_next = count_reg + 61'd1;
        if (cmd.round_start)
        begin
            {a_next, b_next, c_next, d_next} = {ca_reg, cb_reg, cc_reg, cd_reg};
            rnd_next = 6'd0;
        end
        if (cmd.round_step)
        begin
            a_next = d_reg;
            d_next = c_reg;
            c_next = b_reg;
            b_next = b_reg + rot;
            rnd_next = rnd_reg + 6'd1;
        end
        if (cmd.chain_add)
        begin
            ca_next = ca_reg + a_reg;
            cb_next = cb_reg + b_reg;
            cc_next = cc_reg + c_reg;
            cd_next = cd_reg + d_reg;
        end
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        if (cmd.emit_load)
        begin
            ovalid_next = 1'b1;
            oidx_next = 2'd0;
            oword_next = ca_reg;
        end
        else if (cmd.emit_next)
        begin
            ovalid_next = 1'b1;
            oidx_next = oidx_reg + 2'd1;
            case (oidx_reg)
                2'd0:    oword_next = cb_reg;
                2'd1:    oword_next = cc_reg;
                default: oword_next = cd_reg;
            endcase
        end
        if (cmd.msg_clear)
        begin
            {ca_next, cb_next, cc_next, cd_next} = {INIT_A, INIT_B, INIT_C, INIT_D};
            count_next = '0;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            count_reg <= '0;
            rnd_reg <= '0;
            {a_reg, b_reg, c_reg, d_reg} <= '0;
            {ca_reg, cb_reg, cc_reg, cd_reg} <= {INIT_A, INIT_B, INIT_C, INIT_D};
            oidx_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            count_reg <= count_next;
            rnd_reg <= rnd_next;
            {a_reg, b_reg, c_reg, d_reg} <= {a_next, b_next, c_next, d_next};
            {ca_reg, cb_reg, cc_reg, cd_reg} <= {ca_next, cb_next, cc_next, cd_next};
            oidx_reg <= oidx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg <= oword_next;
    end

    assign status.block_full = (pos_reg == 6'd63);
    assign status.pad_done   = (pos_reg == 6'd55);
    assign status.len_done   = (pos_reg == 6'd63);
    assign status.round_last = (rnd_reg == 6'd63);
    assign status.out_busy   = ovalid_reg;
    assign status.out_last   = (oidx_reg == 2'd3);
    assign status.out_take   = ovalid_reg && out_ready;

    assign digest_word = oword_reg;
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 2'd3);

endmodule

/* sv/md5_ctrl.sv */
// MD5 controller: sequences byte intake, rounds, padding, length and digest output.
module md5_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 byte_valid,
    input  logic                 end_of_message,
    input  md5_pkg::md5_status_t status,
    output md5_pkg::md5_cmd_t    cmd,
    output logic                 out_valid
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    // Where to go after the rounds: back to intake, on with padding, or to digest output.
    md5_state_t ret_reg, ret_next;
    logic       take;
    logic       pad_first_reg, pad_first_next;
    logic       emit_started_reg, emit_started_next;

    assign take = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (byte_valid && status.block_full)
                    begin
                        state_next = ST_ROUND;
                        ret_next = end_of_message ? ST_PAD : ST_IDLE;
                    end
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                if (status.round_last)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ret_reg;
            end
            ST_PAD:
            begin
                // Write 0x80 first, then zeros up to offset 56.
                if (status.block_full)
                begin
                    state_next = ST_ROUND;
                    ret_next = ST_PAD;
                end
                else if (status.pad_done)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                if (status.len_done)
                begin
                    state_next = ST_ROUND;
                    ret_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_take && status.out_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        pad_first_next = pad_first_reg;
        emit_started_next = emit_started_reg;
        case (state_reg)
            ST_IDLE:
            begin
                emit_started_next = 1'b0;
                pad_first_next = 1'b1;
                if (take && byte_valid)
                begin
                    cmd.write_byte = 1'b1;
                    cmd.byte_src = BSRC_DATA;
                    cmd.count_inc = 1'b1;
                    cmd.pos_inc = 1'b1;
                    cmd.round_start = status.block_full;
                end
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
            end
            ST_ADD:
            begin
                cmd.chain_add = 1'b1;
            end
            ST_PAD:
            begin
                cmd.write_byte = 1'b1;
                cmd.byte_src = pad_first_reg ? BSRC_PAD : BSRC_ZERO;
                cmd.pos_inc = 1'b1;
                cmd.round_start = status.block_full;
                pad_first_next = 1'b0;
            end
            ST_LEN:
            begin
                cmd.write_byte = 1'b1;
                cmd.byte_src = BSRC_LEN;
                cmd.pos_inc = 1'b1;
                cmd.round_start = status.len_done;
            end
            ST_EMIT:
            begin
                if (!emit_started_reg)
                begin
                    cmd.emit_load = 1'b1;
                    emit_started_next = 1'b1;
                end
                else if (status.out_take && !status.out_last)
                    cmd.emit_next = 1'b1;
                else if (status.out_take && status.out_last)
                    cmd.msg_clear = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            pad_first_reg <= 1'b1;
            emit_started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            pad_first_reg <= pad_first_next;
            emit_started_reg <= emit_started_next;
        end
    end

    assign out_valid = status.out_busy;

endmodule

/* sv/md5_stream_hash.sv */
// Top level of the MD5 stream hash: byte stream in, four digest words out.
//
//  channel | group | tdata (low bit first) | tuser (low bit first) | tlast
//  input   | s_*   | data_byte[7:0]        | byte_valid            | end_of_message
//  output  | m_*   | digest_word[31:0]     | word_index[1:0]       | last_word
//
// The 64th byte of a block starts the round steps and then a chain-add step,
// during which no item is accepted. End of message writes pad and length
// bytes one per cycle (up to 72 more, plus one extra block of rounds), then
// a load of the output register and four output words.
// Reset is asynchronous; it restores the initial chaining words.
// A stalled output register holds its word; input waits until the digest is out.
module md5_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic [1:0]  m_tuser,   // word_index[1:0]
    output logic        m_tlast    // last_word
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_status_t status;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    md5_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .byte_valid     (s_tuser),
        .end_of_message (s_tlast),
        .status         (status),
        .cmd            (cmd),
        .out_valid      (m_tvalid)
    );

    md5_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_byte   (s_tdata),
        .out_ready   (m_tready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    assign m_tdata = digest_word;
    assign m_tuser = word_index;
    assign m_tlast = last_word;

`include "md5_stream_hash_defines.svh"

    `MD5_ASSERT_IMPL(a_no_in_out_busy, clk, rst_n, m_tvalid, !s_tready)
    `MD5_ASSERT_NEXT(a_last_clears, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)
    `MD5_ASSERT_IMPL(a_last_idx, clk, rst_n, m_tvalid && m_tlast, word_index == 2'd3)

endmodule
